/* design/cfm_pkg.sv */
// Package for the cluster fragment/migrate step block.
// Shared types and request/action codes; no dependencies.
`default_nettype none
package cfm_pkg;
  localparam int unsigned MAX_N = 64;
  localparam int unsigned PBITS = 16;

  typedef enum logic [2:0] {
    REQ_INIT  = 3'd0,
    REQ_WFRAG = 3'd1,
    REQ_WMIG  = 3'd2,
    REQ_EVENT = 3'd3,
    REQ_QUERY = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_FRAG = 2'd1,
    ACT_MIG  = 2'd2,
    ACT_ACK  = 2'd3
  } act_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  origin_node;
    logic [5:0]  dest_node;
    logic [6:0]  size_m;
    logic [6:0]  size_n;
    logic [16:0] prob_value;
    logic [15:0] draw_first;
    logic [15:0] draw_second;
    logic [15:0] draw_third;
    logic [6:0]  hist_size;
  } req_t;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] origin_size;
    logic [6:0] dest_size;
    logic [5:0] new_label;
    logic [6:0] hist_count;
  } rsp_t;
endpackage
`default_nettype wire

/* design/cfm_if.sv */
// Valid/ready channel interfaces for request and response items.
// Depends on cfm_pkg.
`default_nettype none
interface cfm_req_if;
  import cfm_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cfm_rsp_if;
  import cfm_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/cfm_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* design/cluster_fragment_migrate_step.sv */
// Cluster fragment/migrate Monte Carlo step. One item in, one result out; a new
// item is taken only once the previous result has been taken. Cluster state
// lives in single-read RAMs with registered read data, and the sequencer
// reads, modifies and writes it back one access at a time, forwarding the last
// histogram write to a read of the same entry. Initialize sweeps all 64
// entries of the label, size, histogram and free-stack RAMs, one entry a
// cycle, and answers once the sweep is done. The next item can be accepted
// in the cycle after the result is taken. Tables are undefined until
// written. Depends on cfm_pkg, cfm_if and cfm_ram.
`default_nettype none
module cluster_fragment_migrate_step (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  cfm_req_if.sink          req_i,
  cfm_rsp_if.source        rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import cfm_pkg::*;

  localparam int unsigned MAX_NODES = MAX_N;
  localparam int unsigned PROB_BITS = PBITS;
  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam logic [PROB_BITS:0] ONE = {1'b1, {PROB_BITS{1'b0}}};
  localparam logic [2:0] ADDR_NUM = 3'd0;
  localparam logic [2:0] ADDR_MODE = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_TW, S_Q1, S_Q2,
    S_E1, S_E2, S_E3, S_E4, S_E5, S_E6,
    S_W1, S_W2, S_W3, S_W4, S_W5, S_W6, S_OUT
  } state_e;

  // configuration registers
  logic [6:0] num_q;
  logic       mode_q;
  wire cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    case (paddr)
      ADDR_NUM:  prdata = {25'd0, num_q};
      ADDR_MODE: prdata = {31'd0, mode_q};
      default:   prdata = 32'd0;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= 7'd8;
      mode_q <= 1'b0;
    end else if (cfg_we) begin
      if (paddr == ADDR_NUM) num_q <= pwdata[6:0];
      if (paddr == ADDR_MODE) mode_q <= pwdata[0];
    end
  end

  // memories
  logic          lb_we, gs_we, hs_we, fl_we, ft_we, mt_we;
  logic [AW-1:0] lb_wa, lb_ra, gs_wa, gs_ra, fl_wa, fl_ra;
  logic [5:0]    hs_wa, hs_ra;
  logic [11:0]   t_wa, t_ra;
  logic [AW-1:0] lb_wd, fl_wd, lb_rd, fl_rd;
  logic [6:0]    gs_wd, gs_rd, hs_wd, hs_rd;
  logic [PROB_BITS:0] t_wd, ft_rd, mt_rd;

  cfm_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_lb (.clk_i, .we_i(lb_we),
    .waddr_i(lb_wa), .wdata_i(lb_wd), .raddr_i(lb_ra), .rdata_o(lb_rd));
  cfm_ram #(.WIDTH(7), .DEPTH(MAX_NODES)) u_gs (.clk_i, .we_i(gs_we),
    .waddr_i(gs_wa), .wdata_i(gs_wd), .raddr_i(gs_ra), .rdata_o(gs_rd));
  cfm_ram #(.WIDTH(7), .DEPTH(64)) u_hs (.clk_i, .we_i(hs_we),
    .waddr_i(hs_wa), .wdata_i(hs_wd), .raddr_i(hs_ra), .rdata_o(hs_rd));
  cfm_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_fl (.clk_i, .we_i(fl_we),
    .waddr_i(fl_wa), .wdata_i(fl_wd), .raddr_i(fl_ra), .rdata_o(fl_rd));
  cfm_ram #(.WIDTH(PROB_BITS+1), .DEPTH(4096)) u_ft (.clk_i, .we_i(ft_we),
    .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(ft_rd));
  cfm_ram #(.WIDTH(PROB_BITS+1), .DEPTH(4096)) u_mt (.clk_i, .we_i(mt_we),
    .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(mt_rd));

  // sequencer state
  state_e state_q;
  req_t   r_q;
  rsp_t   rsp_q;
  logic   rv_q;
  logic [6:0] act_q, fc_q, cnt_q;
  logic [AW-1:0] lo_q, ld_q, nl_q;
  logic [6:0] m_q, n_q;
  logic [1:0] act_e_q;
  logic [6:0] h_q;
  logic       hf_q;
  logic [PROB_BITS+7:0] pr1_q, pr2_q;

  assign req_i.ready = (state_q == S_IDLE) && !rv_q;
  assign rsp_o.valid = rv_q;
  assign rsp_o.data  = rsp_q;
  wire acc = req_i.valid && req_i.ready;

  logic [6:0] nsat;
  always_comb begin
    nsat = num_q;
    if (num_q < 7'd2) nsat = 7'd2;
    if (num_q > 7'(MAX_NODES)) nsat = 7'(MAX_NODES);
  end

  wire [PROB_BITS-1:0] d1 = r_q.draw_first[PROB_BITS-1:0];
  wire [PROB_BITS-1:0] d2 = r_q.draw_second[PROB_BITS-1:0];
  wire [PROB_BITS-1:0] d3 = r_q.draw_third[PROB_BITS-1:0];
  wire [PROB_BITS:0] pv_sat = (r_q.prob_value > 17'(ONE)) ? ONE : r_q.prob_value[PROB_BITS:0];
  wire sm_ok = r_q.size_m >= 7'd1 && r_q.size_m <= 7'd64;
  wire sn_ok = r_q.size_n >= 7'd1 && r_q.size_n <= 7'd64;
  wire [6:0] smi = r_q.size_m - 7'd1;
  wire [6:0] sni = r_q.size_n - 7'd1;
  wire [6:0] mi = (m_q >= 7'd1 && m_q <= 7'd64) ? m_q - 7'd1 : 7'd0;
  // destination size straight from the size RAM, used to address the tables
  wire [6:0] nri = (gs_rd >= 7'd1 && gs_rd <= 7'd64) ? gs_rd - 7'd1 : 7'd0;
  wire [6:0] hq = r_q.hist_size - 7'd1;
  // histogram read data with the previous cycle's write forwarded
  wire [6:0] hv = hf_q ? h_q : hs_rd;

  // memory port drive, by state
  always_comb begin
    lb_we = 1'b0; gs_we = 1'b0; hs_we = 1'b0; fl_we = 1'b0;
    ft_we = 1'b0; mt_we = 1'b0;
    lb_wa = cnt_q[AW-1:0]; lb_wd = '0; lb_ra = r_q.origin_node[AW-1:0];
    gs_wa = cnt_q[AW-1:0]; gs_wd = '0; gs_ra = lo_q;
    hs_wa = cnt_q[5:0];    hs_wd = '0; hs_ra = hq[5:0];
    fl_wa = cnt_q[AW-1:0]; fl_wd = '0; fl_ra = AW'(fc_q - 7'd1);
    t_wa = {smi[5:0], sni[5:0]}; t_wd = pv_sat; t_ra = {mi[5:0], nri[5:0]};
    case (state_q)
      S_INIT: begin
        lb_we = 1'b1; gs_we = 1'b1; hs_we = 1'b1; fl_we = 1'b1;
        lb_wd = mode_q ? cnt_q[AW-1:0] : '0;
        if (mode_q) gs_wd = (cnt_q < nsat) ? 7'd1 : 7'd0;
        else gs_wd = (cnt_q == 7'd0) ? nsat : 7'd0;
        if (mode_q) hs_wd = (cnt_q == 7'd0) ? nsat : 7'd0;
        else hs_wd = (cnt_q == nsat - 7'd1) ? 7'd1 : 7'd0;
        fl_wd = (cnt_q + 7'd1 < nsat) ? AW'(nsat - 7'd1 - cnt_q) : '0;
      end
      S_TW: begin
        ft_we = sm_ok && sn_ok && r_q.req_type == REQ_WFRAG;
        mt_we = sm_ok && sn_ok && r_q.req_type == REQ_WMIG;
      end
      S_E2: lb_ra = r_q.dest_node[AW-1:0];
      S_E4: gs_ra = ld_q;
      S_W1: begin  // origin cluster shrinks
        gs_we = 1'b1; gs_wa = lo_q; gs_wd = m_q - 7'd1;
        hs_ra = 6'(m_q - 7'd1);
      end
      S_W2: begin  // hist[m]-- ; read hist[m-1]
        hs_we = (m_q >= 7'd1 && m_q <= 7'd64);
        hs_wa = 6'(m_q - 7'd1); hs_wd = hv - 7'd1;
        hs_ra = 6'(m_q - 7'd2);
      end
      S_W3: begin  // hist[m-1]++ ; second cluster grows
        hs_we = (m_q >= 7'd2 && m_q <= 7'd65);
        hs_wa = 6'(m_q - 7'd2); hs_wd = hv + 7'd1;
        gs_we = 1'b1;
        if (act_e_q == ACT_FRAG) begin
          gs_wa = nl_q; gs_wd = 7'd1; hs_ra = 6'd0;
        end else begin
          gs_wa = ld_q; gs_wd = n_q + 7'd1; hs_ra = 6'(n_q - 7'd1);
        end
        fl_we = (act_e_q == ACT_MIG) && m_q <= 7'd1 && fc_q < 7'(MAX_NODES);
        fl_wa = fc_q[AW-1:0]; fl_wd = lo_q;
        lb_we = 1'b1; lb_wa = r_q.origin_node[AW-1:0];
        lb_wd = (act_e_q == ACT_FRAG) ? nl_q : ld_q;
      end
      S_W4: begin
        if (act_e_q == ACT_FRAG) begin
          hs_we = 1'b1; hs_wa = 6'd0; hs_wd = hv + 7'd1;
        end else begin
          hs_we = (n_q >= 7'd1 && n_q <= 7'd64);
          hs_wa = 6'(n_q - 7'd1); hs_wd = hv - 7'd1;
          hs_ra = 6'(n_q);
        end
      end
      S_W5: begin
        hs_we = (n_q <= 7'd63);
        hs_wa = 6'(n_q); hs_wd = hv + 7'd1;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q    <= 1'b0;
      act_q   <= 7'd0;
      fc_q    <= 7'd0;
      cnt_q   <= 7'd0;
    end else begin
      if (rv_q && rsp_o.ready) rv_q <= 1'b0;
      case (state_q)
        S_IDLE: if (acc) begin
          r_q   <= req_i.data;
          rsp_q <= '0;
          cnt_q <= 7'd0;
          case (req_i.data.req_type)
            REQ_INIT:  state_q <= S_INIT;
            REQ_WFRAG, REQ_WMIG: state_q <= S_TW;
            REQ_EVENT: state_q <= S_E1;
            REQ_QUERY: state_q <= S_Q1;
            default:   state_q <= S_OUT;
          endcase
        end
        S_INIT: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(MAX_NODES - 1)) begin
            act_q <= nsat;
            fc_q  <= mode_q ? 7'd0 : nsat - 7'd1;
            rsp_q.action <= ACT_ACK;
            state_q <= S_OUT;
          end
        end
        S_TW: begin
          rsp_q.action <= ACT_ACK;
          state_q <= S_OUT;
        end
        S_Q1: state_q <= S_Q2;
        S_Q2: begin
          rsp_q.action <= ACT_ACK;
          if (r_q.hist_size >= 7'd1 && r_q.hist_size <= 7'd64) rsp_q.hist_count <= hs_rd;
          state_q <= S_OUT;
        end
        S_E1: begin
          if (7'(r_q.origin_node) >= act_q || 7'(r_q.dest_node) >= act_q) state_q <= S_OUT;
          else state_q <= S_E2;
        end
        S_E2: begin lo_q <= lb_rd; state_q <= S_E3; end
        S_E3: begin ld_q <= lb_rd; state_q <= S_E4; end
        S_E4: begin m_q <= gs_rd; state_q <= S_E5; end
        S_E5: begin
          n_q <= gs_rd;
          pr1_q <= d1 * (gs_rd + 7'd1);
          pr2_q <= d1 * m_q;
          state_q <= S_E6;
        end
        S_E6: begin
          logic [1:0] a;
          a = ACT_NONE;
          if (r_q.origin_node != r_q.dest_node) begin
            if (lo_q != ld_q && m_q > 7'd1) begin
              if ({1'b0, d1} <= ft_rd) a = ACT_FRAG;
              else if ({1'b0, d2} > ft_rd &&
                       {2'b0, d3} <= {1'b0, ft_rd} + {1'b0, mt_rd}) a = ACT_MIG;
            end else if (lo_q != ld_q) begin
              if (pr1_q <= (PROB_BITS+8)'(ONE)) a = ACT_MIG;
            end else if (m_q > 7'd1) begin
              if (pr2_q <= (PROB_BITS+8)'(ONE)) a = ACT_FRAG;
            end
          end
          if (a == ACT_FRAG && fc_q == 7'd0) a = ACT_NONE;
          act_e_q <= a;
          rsp_q.origin_size <= m_q;
          rsp_q.dest_size   <= n_q;
          rsp_q.new_label   <= 6'(lo_q);
          rsp_q.action      <= a;
          if (a == ACT_NONE) state_q <= S_OUT;
          else state_q <= S_W1;
          if (a == ACT_FRAG) fc_q <= fc_q - 7'd1;
        end
        S_W1: begin
          if (act_e_q == ACT_FRAG) nl_q <= fl_rd;
          state_q <= S_W2;
        end
        S_W2: begin state_q <= S_W3; end
        S_W3: begin
          rsp_q.new_label <= 6'((act_e_q == ACT_FRAG) ? nl_q : ld_q);
          if (fl_we) fc_q <= fc_q + 7'd1;
          state_q <= S_W4;
        end
        S_W4: state_q <= (act_e_q == ACT_FRAG) ? S_OUT : S_W5;
        S_W5: state_q <= S_OUT;
        S_OUT: begin rv_q <= 1'b1; state_q <= S_IDLE; end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // last histogram write, forwarded when the next read hits the same entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hf_q <= 1'b0;
      h_q  <= 7'd0;
    end else begin
      hf_q <= hs_we && (hs_wa == hs_ra);
      h_q  <= hs_wd;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) acc |=> !req_i.ready);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> state_q == S_IDLE) else $error("result held outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= 7'(MAX_NODES)) else $error("free count overflow");
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Testbench for cluster_fragment_migrate_step: directed and random items,
// checked against an in-order cluster state predictor kept in a scoreboard class.
// Depends on cfm_pkg, cfm_if and the block's RTL.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cfm_pkg::*;

  localparam logic [2:0] ADDR_NODES = 3'd0;
  localparam logic [2:0] ADDR_MODE  = 3'd4;
  localparam int unsigned ONE_Q      = 65536;

  // Cluster state predictor and expected result store
  class cluster_scoreboard;
    int unsigned num_nodes_r;
    int unsigned init_mode_r;
    int unsigned active;
    bit [5:0]    label_of[64];
    bit [6:0]    gsize[64];
    bit [6:0]    hist[64];
    bit [5:0]    free_lbl[64];
    int unsigned free_cnt;
    bit [16:0]   frag_tab[4096];
    bit [16:0]   mig_tab[4096];
    bit          frag_seen[4096];
    bit          mig_seen[4096];
    rsp_t        pending[$];
    int          errors;

    function new();
      num_nodes_r = 8;
      init_mode_r = 0;
      active = 0;
      free_cnt = 0;
      errors = 0;
      for (int i = 0; i < 64; i++) begin
        label_of[i] = 0; gsize[i] = 0; hist[i] = 0; free_lbl[i] = 0;
      end
      for (int i = 0; i < 4096; i++) begin
        frag_tab[i] = 0; mig_tab[i] = 0; frag_seen[i] = 0; mig_seen[i] = 0;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void hist_bump(int unsigned sz, int delta);
      if (sz >= 1 && sz <= 64) hist[sz-1] = 7'(int'(hist[sz-1]) + delta);
    endfunction

    function void rebuild();
      int unsigned n;
      n = num_nodes_r;
      if (n < 2) n = 2;
      if (n > 64) n = 64;
      active = n;
      free_cnt = 0;
      for (int i = 0; i < 64; i++) begin
        label_of[i] = 0; gsize[i] = 0; hist[i] = 0; free_lbl[i] = 0;
      end
      if (init_mode_r == 0) begin
        gsize[0] = 7'(n);
        hist_bump(n, 1);
        for (int i = 0; i + 1 < n; i++) free_lbl[i] = 6'(n - 1 - i);
        free_cnt = n - 1;
      end else begin
        for (int i = 0; i < n; i++) begin
          label_of[i] = 6'(i);
          gsize[i] = 1;
        end
        hist_bump(1, n);
      end
    endfunction

    // Table index an event would read, or -1 when it reads none
    function int table_index(req_t r);
      int unsigned o, d, lo, ld, m, n;
      o = r.origin_node; d = r.dest_node;
      if (r.req_type != REQ_EVENT || o >= active || d >= active || o == d) return -1;
      lo = label_of[o]; ld = label_of[d];
      m = gsize[lo]; n = gsize[ld];
      if (lo == ld || m <= 1) return -1;
      return int'(((m >= 1 && m <= 64) ? m - 1 : 0) * 64 + ((n >= 1 && n <= 64) ? n - 1 : 0));
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int unsigned o, d, lo, ld, m, n, nl, sm, sn, idx;
      longint unsigned p, q, d1, d2, d3;
      act_e act;
      e = '0;
      case (r.req_type)
        REQ_INIT: begin
          rebuild();
          e.action = ACT_ACK;
        end
        REQ_WFRAG, REQ_WMIG: begin
          sm = r.size_m; sn = r.size_n;
          if (sm >= 1 && sm <= 64 && sn >= 1 && sn <= 64) begin
            idx = (sm - 1) * 64 + (sn - 1);
            if (r.req_type == REQ_WFRAG) begin
              frag_tab[idx] = (r.prob_value > ONE_Q) ? 17'(ONE_Q) : r.prob_value;
              frag_seen[idx] = 1;
            end else begin
              mig_tab[idx] = (r.prob_value > ONE_Q) ? 17'(ONE_Q) : r.prob_value;
              mig_seen[idx] = 1;
            end
          end
          e.action = ACT_ACK;
        end
        REQ_EVENT: begin
          o = r.origin_node; d = r.dest_node;
          d1 = r.draw_first; d2 = r.draw_second; d3 = r.draw_third;
          if (o < active && d < active) begin
            lo = label_of[o]; ld = label_of[d];
            m = gsize[lo]; n = gsize[ld];
            e.origin_size = 7'(m);
            e.dest_size = 7'(n);
            act = ACT_NONE;
            if (o != d) begin
              if (lo != ld && m > 1) begin
                idx = ((m <= 64) ? m - 1 : 0) * 64 + ((n >= 1 && n <= 64) ? n - 1 : 0);
                p = frag_tab[idx];
                q = mig_tab[idx];
                if (d1 <= p) act = ACT_FRAG;
                else if (d2 > p && d3 <= p + q) act = ACT_MIG;
              end else if (lo != ld) begin
                if (d1 * (n + 1) <= ONE_Q) act = ACT_MIG;
              end else if (m > 1) begin
                if (d1 * m <= ONE_Q) act = ACT_FRAG;
              end
            end
            if (act == ACT_FRAG && free_cnt == 0) act = ACT_NONE;
            if (act == ACT_FRAG) begin
              free_cnt--;
              nl = free_lbl[free_cnt];
              gsize[lo] = 7'(m - 1);
              hist_bump(m, -1);
              hist_bump(m - 1, 1);
              gsize[nl] = 1;
              hist_bump(1, 1);
              label_of[o] = 6'(nl);
            end else if (act == ACT_MIG) begin
              gsize[lo] = 7'(m - 1);
              hist_bump(m, -1);
              hist_bump(m - 1, 1);
              if (m <= 1 && free_cnt < 64) begin
                free_lbl[free_cnt] = 6'(lo);
                free_cnt++;
              end
              gsize[ld] = 7'(n + 1);
              hist_bump(n, -1);
              hist_bump(n + 1, 1);
              label_of[o] = 6'(ld);
            end
            e.action = act;
            e.new_label = label_of[o];
          end
        end
        REQ_QUERY: begin
          if (r.hist_size >= 1 && r.hist_size <= 64) e.hist_count = hist[r.hist_size-1];
          e.action = ACT_ACK;
        end
        default: e = '0;
      endcase
      pending = {pending, e};
    endfunction

    task check_response(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      e = pending.pop_front();
      if (got.action !== e.action)
        report($sformatf("action %0d, expected %0d", got.action, e.action));
      if (got.origin_size !== e.origin_size)
        report($sformatf("origin_size %0d, expected %0d", got.origin_size, e.origin_size));
      if (got.dest_size !== e.dest_size)
        report($sformatf("dest_size %0d, expected %0d", got.dest_size, e.dest_size));
      if (got.new_label !== e.new_label)
        report($sformatf("new_label %0d, expected %0d", got.new_label, e.new_label));
      if (got.hist_count !== e.hist_count)
        report($sformatf("hist_count %0d, expected %0d", got.hist_count, e.hist_count));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cfm_req_if req_ch();
  cfm_rsp_if rsp_ch();

  cluster_fragment_migrate_step dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_ch.sink), .rsp_o(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cluster_scoreboard sb;
  bit quiet;        // no idling on either side
  int results_seen;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Offer one item; returns at the edge where it is taken, valid left high
  task send_item(req_t r);
    if (!quiet && $urandom_range(99) < 13) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note_request(r);
  endtask

  // Event with any unwritten table entry it needs loaded first
  task send_event(req_t r);
    req_t w;
    int idx;
    idx = sb.table_index(r);
    if (idx >= 0 && !sb.frag_seen[idx]) begin
      w = '0; w.req_type = REQ_WFRAG;
      w.size_m = 7'(idx / 64 + 1); w.size_n = 7'(idx % 64 + 1);
      w.prob_value = 17'($urandom_range(0, 30000));
      send_item(w);
    end
    if (idx >= 0 && !sb.mig_seen[idx]) begin
      w = '0; w.req_type = REQ_WMIG;
      w.size_m = 7'(idx / 64 + 1); w.size_n = 7'(idx % 64 + 1);
      w.prob_value = 17'($urandom_range(0, 40000));
      send_item(w);
    end
    send_item(r);
  endtask

  // Let the block go idle before touching registers
  task drain();
    req_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task apb_write(input logic [2:0] addr, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_NODES) sb.num_nodes_r = val & 32'h7F;
    else sb.init_mode_r = val & 32'h1;
  endtask

  function automatic req_t mk(req_e t);
    req_t r;
    r = '0;
    r.req_type = t;
    return r;
  endfunction

  function automatic req_t mk_event(int unsigned o, int unsigned d, int unsigned d1);
    req_t r;
    r = mk(REQ_EVENT);
    r.origin_node = 6'(o); r.dest_node = 6'(d); r.draw_first = 16'(d1);
    r.draw_second = 16'hFFFF; r.draw_third = 16'h0000;
    return r;
  endfunction

  function automatic req_t random_item(int unsigned span);
    req_t r;
    int unsigned k;
    r = '0;
    r.origin_node = 6'($urandom_range(0, span - 1));
    r.dest_node = 6'($urandom_range(0, span - 1));
    r.draw_first = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
    r.draw_second = 16'($urandom);
    r.draw_third = 16'($urandom);
    k = $urandom_range(99);
    if (k < 70) r.req_type = REQ_EVENT;
    else if (k < 78) begin
      r.req_type = REQ_QUERY;
      r.hist_size = ($urandom_range(7) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
    end else if (k < 90) begin
      r.req_type = ($urandom_range(1)) ? REQ_WFRAG : REQ_WMIG;
      r.size_m = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 8));
      r.size_n = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 8));
      r.prob_value = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 40000));
    end else if (k < 94) begin
      // noise: nodes anywhere, reserved codes
      r.origin_node = 6'($urandom);
      r.dest_node = 6'($urandom);
      r.req_type = ($urandom_range(1)) ? REQ_EVENT : 3'($urandom_range(5, 7));
      r.size_m = 7'($urandom); r.size_n = 7'($urandom); r.prob_value = 17'($urandom);
      r.hist_size = 7'($urandom);
    end else if (k < 95) r.req_type = REQ_INIT;
    else begin
      // lone or same-cluster style event with a tiny first draw
      r.req_type = REQ_EVENT;
      r.draw_first = 16'($urandom_range(0, 600));
    end
    return r;
  endfunction

  // Stimulus
  initial begin
    req_t r;
    int unsigned nodes_set[6];
    int unsigned span;
    sb = new();
    quiet = 1'b0;
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: event before any initialize gives all zero
    send_item(mk_event(0, 1, 0));
    drain();
    apb_write(ADDR_NODES, 8);
    apb_write(ADDR_MODE, 0);
    send_item(mk(REQ_INIT));
    r = mk(REQ_QUERY); r.hist_size = 8; send_item(r);
    r.hist_size = 0; send_item(r);
    r.hist_size = 7'h7F; send_item(r);
    // table writes: extremes, out-of-range index, value saturation
    r = mk(REQ_WFRAG); r.size_m = 1; r.size_n = 1; r.prob_value = 0; send_item(r);
    r.size_m = 64; r.size_n = 64; r.prob_value = 17'h1FFFF; send_item(r);
    r.size_m = 0; r.size_n = 5; send_item(r);
    r.size_m = 65; r.size_n = 1; send_item(r);
    r = mk(REQ_WMIG); r.size_m = 1; r.size_n = 64; r.prob_value = 17'd65536; send_item(r);
    // same cluster fragments with a zero draw, origin equals destination, range
    send_item(mk_event(0, 1, 0));
    send_item(mk_event(2, 2, 0));
    send_item(mk_event(8, 1, 0));
    send_item(mk_event(1, 63, 0));
    // lone origin: migrates on zero draw, stays on full draw
    send_item(mk_event(0, 3, 16'hFFFF));
    send_item(mk_event(0, 3, 0));
    send_event(mk_event(4, 0, 0));
    r = mk_event(5, 0, 16'hFFFF); r.draw_second = 16'hFFFF; r.draw_third = 0;
    send_event(r);
    send_item(mk(req_e'(3'd5)));
    send_item(mk(req_e'(3'd6)));
    r = mk(req_e'(3'd7)); r.origin_node = 6'h3F; send_item(r);
    r = mk(REQ_QUERY); r.hist_size = 1; send_item(r);
    drain();

    // Random phases over several register settings
    nodes_set[0] = 2;  nodes_set[1] = 64; nodes_set[2] = 5;
    nodes_set[3] = 0;  nodes_set[4] = 127; nodes_set[5] = 12;
    for (int ph = 0; ph < 12; ph++) begin
      apb_write(ADDR_NODES, nodes_set[ph % 6]);
      apb_write(ADDR_MODE, ph % 2);
      send_item(mk(REQ_INIT));
      span = sb.active;
      for (int i = 0; i < 125; i++) begin
        quiet = (ph == 5);
        r = random_item(span);
        if (r.req_type == REQ_INIT) begin
          // reinit only reads registers already latched; nothing undefined
          send_item(r);
          span = sb.active;
        end else if (r.req_type == REQ_EVENT) send_event(r);
        else send_item(r);
      end
      quiet = 1'b0;
      drain();
    end

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Result side: random stalls, one long hold-off to back up the block
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    results_seen = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
        sb.check_response(rsp_ch.data);
        results_seen++;
      end
      if (!held && results_seen == 300) begin
        held = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 13);
      end
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
